// ===== src/tbkg_pkg.sv =====
`default_nettype none

package tbkg_pkg;

  // left half of the matrix is the columns below COLUMNS / 2
  localparam int unsigned COLUMNS = 16;
  localparam int unsigned HALF_COLUMNS = COLUMNS / 2;

  localparam int unsigned MS_PER_SECOND = 1000;

  // reciprocal of 1000 for a 32-bit dividend: floor(x / 1000) = (x * RECIP) >> RECIP_SHIFT
  localparam logic [31:0] RECIP_1000 = 32'h1062_4DD3;
  localparam int unsigned RECIP_SHIFT = 38;

  // configuration register indexes
  localparam logic [2:0] CFG_IDLE_LIMIT    = 3'd0;
  localparam logic [2:0] CFG_SESSION_LIMIT = 3'd1;
  localparam logic [2:0] CFG_BREAK_LENGTH  = 3'd2;
  localparam logic [2:0] CFG_LEFT_LIMIT    = 3'd3;
  localparam logic [2:0] CFG_RIGHT_LIMIT   = 3'd4;

  // configuration reset values in seconds
  localparam logic [15:0] IDLE_LIMIT_RESET    = 16'd300;
  localparam logic [15:0] SESSION_LIMIT_RESET = 16'd2700;
  localparam logic [15:0] BREAK_LENGTH_RESET  = 16'd300;

  // verdict codes
  localparam logic [1:0] VERDICT_PASS     = 2'd0;
  localparam logic [1:0] VERDICT_ABORT    = 2'd1;
  localparam logic [1:0] VERDICT_CONSUMED = 2'd2;

  // lock transition codes
  localparam logic [1:0] LOCK_EVENT_NONE    = 2'd0;
  localparam logic [1:0] LOCK_EVENT_STARTED = 2'd1;
  localparam logic [1:0] LOCK_EVENT_ENDED   = 2'd2;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        is_release;
    logic [3:0]  key_column;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [1:0]  lock_event;
    logic        is_locked;
    logic [15:0] left_presses;
    logic [15:0] right_presses;
    logic [15:0] break_seconds_left;
  } out_word_t;

  // seconds to milliseconds, constant multiply
  function automatic logic [31:0] ms_from_seconds(input logic [15:0] sec);
    ms_from_seconds = 32'(sec) * 32'(MS_PER_SECOND);
  endfunction

  // low 16 bits of ms / 1000 by reciprocal multiply
  function automatic logic [15:0] seconds_from_ms(input logic [31:0] ms);
    logic [63:0] prod;
    prod = 64'(ms) * 64'(RECIP_1000);
    seconds_from_ms = prod[RECIP_SHIFT +: 16];
  endfunction

endpackage

`default_nettype wire

// ===== src/typing_break_key_gate.sv =====
// typing break key gate
// a word moves from the input register to the result register, and each holds its word while the stage after it stalls
// throughput: one word per cycle while out_ready is high; the ms to seconds multiply sits before the input register
// lock, session and counter state update as a word moves into the result register
// reset (rst, synchronous): unlocked, counters and times cleared, registers back to defaults
`default_nettype none

module typing_break_key_gate #(
  parameter int unsigned COLUMNS = tbkg_pkg::COLUMNS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tbkg_pkg::in_word_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tbkg_pkg::out_word_t    out_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);

  // columns below this are the left hand
  localparam int unsigned HALF_COLUMNS = COLUMNS / 2;

  // configuration, time limits kept in milliseconds (break length also in seconds), key limits as counts
  logic [31:0] idle_ms;
  logic [31:0] session_ms;
  logic [31:0] break_ms;
  logic [15:0] break_len;
  logic [15:0] left_limit;
  logic [15:0] right_limit;

  // input register
  logic                 s1_valid;
  tbkg_pkg::in_word_t   s1_data;
  logic [15:0]          s1_now_sec;

  // gate state
  logic        locked;
  logic [31:0] session_start_ms;
  logic [31:0] last_key_ms;
  logic [15:0] last_key_sec;
  logic [31:0] break_start_ms;
  logic [15:0] break_start_sec;
  logic [15:0] left_keys;
  logic [15:0] right_keys;

  // next state
  logic        locked_next;
  logic [31:0] session_start_ms_next;
  logic [15:0] left_keys_next;
  logic [15:0] right_keys_next;
  logic [31:0] break_start_ms_next;
  logic [15:0] break_start_sec_next;

  logic        advance;
  logic        fire;
  logic        press;
  logic        break_over;
  logic        abort;
  logic        unlock;
  logic        active;
  logic        idle_over;
  logic        restart;
  logic [15:0] cnt_l;
  logic [15:0] cnt_r;
  logic [31:0] session_elapsed;
  logic        due;
  logic        start_break;
  logic        count_key;
  logic        is_left;
  tbkg_pkg::out_word_t res;

  // handshake: result register frees the input register
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign fire     = s1_valid && advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ms     <= tbkg_pkg::ms_from_seconds(tbkg_pkg::IDLE_LIMIT_RESET);
      session_ms  <= tbkg_pkg::ms_from_seconds(tbkg_pkg::SESSION_LIMIT_RESET);
      break_ms    <= tbkg_pkg::ms_from_seconds(tbkg_pkg::BREAK_LENGTH_RESET);
      break_len   <= tbkg_pkg::BREAK_LENGTH_RESET;
      left_limit  <= '0;
      right_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tbkg_pkg::CFG_IDLE_LIMIT:    idle_ms <= tbkg_pkg::ms_from_seconds(cfg_data);
        tbkg_pkg::CFG_SESSION_LIMIT: session_ms <= tbkg_pkg::ms_from_seconds(cfg_data);
        tbkg_pkg::CFG_BREAK_LENGTH: begin
          break_ms  <= tbkg_pkg::ms_from_seconds(cfg_data);
          break_len <= cfg_data;
        end
        tbkg_pkg::CFG_LEFT_LIMIT:    left_limit <= cfg_data;
        tbkg_pkg::CFG_RIGHT_LIMIT:   right_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register, with the time already in whole seconds
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data    <= in_data;
      s1_now_sec <= tbkg_pkg::seconds_from_ms(in_data.now_ms);
    end
  end

  // gate decision for the word in the input register
  always_comb begin
    press      = !s1_data.is_release;
    break_over = (s1_data.now_ms - break_start_ms) > break_ms;
    abort      = press && locked && !break_over;
    unlock     = press && locked && break_over;
    active     = press && !abort;
    idle_over  = (s1_data.now_ms - last_key_ms) > idle_ms;
    restart    = unlock || (active && idle_over);

    cnt_l                 = restart ? '0 : left_keys;
    cnt_r                 = restart ? '0 : right_keys;
    session_start_ms_next = restart ? s1_data.now_ms : session_start_ms;
    session_elapsed       = restart ? '0 : (s1_data.now_ms - session_start_ms);

    due = ((left_limit != '0) && (cnt_l >= left_limit))
       || ((right_limit != '0) && (cnt_r >= right_limit))
       || ((session_ms != '0) && (session_elapsed > session_ms));

    start_break = active && due;
    count_key   = active && !due;
    is_left     = 32'(s1_data.key_column) < HALF_COLUMNS;

    left_keys_next  = (count_key && is_left) ? cnt_l + 16'd1 : cnt_l;
    right_keys_next = (count_key && !is_left) ? cnt_r + 16'd1 : cnt_r;

    if (start_break) begin
      locked_next = 1'b1;
    end else if (unlock) begin
      locked_next = 1'b0;
    end else begin
      locked_next = locked;
    end

    break_start_ms_next  = start_break ? last_key_ms : break_start_ms;
    break_start_sec_next = start_break ? last_key_sec : break_start_sec;

    // result word
    if (abort) begin
      res.verdict = tbkg_pkg::VERDICT_ABORT;
    end else if (start_break) begin
      res.verdict = tbkg_pkg::VERDICT_CONSUMED;
    end else begin
      res.verdict = tbkg_pkg::VERDICT_PASS;
    end

    if (start_break) begin
      res.lock_event = tbkg_pkg::LOCK_EVENT_STARTED;
    end else if (unlock) begin
      res.lock_event = tbkg_pkg::LOCK_EVENT_ENDED;
    end else begin
      res.lock_event = tbkg_pkg::LOCK_EVENT_NONE;
    end

    res.is_locked          = locked_next;
    res.left_presses       = left_keys_next;
    res.right_presses      = right_keys_next;
    res.break_seconds_left = locked_next
                           ? break_len - (s1_now_sec - break_start_sec_next)
                           : '0;
  end

  // state update as the word leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      locked           <= 1'b0;
      session_start_ms <= '0;
      last_key_ms      <= '0;
      last_key_sec     <= '0;
      break_start_ms   <= '0;
      break_start_sec  <= '0;
      left_keys        <= '0;
      right_keys       <= '0;
    end else if (fire) begin
      locked           <= locked_next;
      session_start_ms <= session_start_ms_next;
      break_start_ms   <= break_start_ms_next;
      break_start_sec  <= break_start_sec_next;
      left_keys        <= left_keys_next;
      right_keys       <= right_keys_next;
      if (count_key) begin
        last_key_ms  <= s1_data.now_ms;
        last_key_sec <= s1_now_sec;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= res;
    end
  end

  // checks
  a_abort_locked: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.verdict == tbkg_pkg::VERDICT_ABORT) |-> out_data.is_locked)
    else $error("aborted word reported unlocked");

  a_consumed_starts: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.verdict == tbkg_pkg::VERDICT_CONSUMED)
    |-> (out_data.lock_event == tbkg_pkg::LOCK_EVENT_STARTED) && out_data.is_locked)
    else $error("consumed word without break start");

  a_ended_unlocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.lock_event == tbkg_pkg::LOCK_EVENT_ENDED)
    |-> !out_data.is_locked && (out_data.verdict == tbkg_pkg::VERDICT_PASS))
    else $error("break end with lock still held");

  a_unlocked_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_locked |-> (out_data.break_seconds_left == '0))
    else $error("seconds left while unlocked");

  a_release_keeps_state: assert property (@(posedge clk) disable iff (rst)
    fire && s1_data.is_release
    |=> $stable(locked) && $stable(left_keys) && $stable(right_keys))
    else $error("release changed gate state");

endmodule

`default_nettype wire

// ===== tb/tb_typing_break_key_gate.sv =====
`default_nettype none

module tb_typing_break_key_gate;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_WAIT = 12;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  tbkg_pkg::in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  tbkg_pkg::out_word_t out_data;
  logic      cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  typing_break_key_gate dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted gate settings, mirrors of the block registers
  logic [15:0] idle_cfg    = tbkg_pkg::IDLE_LIMIT_RESET;
  logic [15:0] session_cfg = tbkg_pkg::SESSION_LIMIT_RESET;
  logic [15:0] break_cfg   = tbkg_pkg::BREAK_LENGTH_RESET;
  logic [15:0] left_lim    = '0;
  logic [15:0] right_lim   = '0;

  // predicted gate state
  logic        locked        = 1'b0;
  logic [31:0] session_start = '0;
  logic [31:0] last_press    = '0;
  logic [31:0] break_start   = '0;
  logic [15:0] left_n        = '0;
  logic [15:0] right_n       = '0;

  tbkg_pkg::in_word_t  pending_events[$];
  tbkg_pkg::out_word_t expected_words[$];
  logic      tx_busy;
  logic      tx_idle_on = 1'b0;
  logic      rx_idle_on = 1'b0;
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  logic [31:0] clock_ms   = '0;

  int unsigned mismatch_count = 0;
  int unsigned words_checked  = 0;
  int unsigned events_total   = 0;
  int unsigned releases_seen  = 0;
  int unsigned aborts_seen    = 0;
  int unsigned breaks_started = 0;
  int unsigned breaks_ended   = 0;
  int unsigned cycle_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void begin_session(logic [31:0] t);
    left_n = '0;
    right_n = '0;
    session_start = t;
  endfunction

  // gate behavior: one result word per key event, updates predicted state
  function automatic tbkg_pkg::out_word_t gate_key_event(tbkg_pkg::in_word_t ev);
    tbkg_pkg::out_word_t r;
    logic [31:0] brk_ms;
    logic [31:0] idle_ms;
    logic [31:0] sess_ms;
    logic [31:0] span;
    logic [31:0] secs;
    logic        done;
    logic        due;
    brk_ms  = {16'h0, break_cfg} * 32'd1000;
    idle_ms = {16'h0, idle_cfg} * 32'd1000;
    sess_ms = {16'h0, session_cfg} * 32'd1000;
    r = '0;
    r.verdict = tbkg_pkg::VERDICT_PASS;
    r.lock_event = tbkg_pkg::LOCK_EVENT_NONE;
    done = ev.is_release;

    // press during a break: abort or end the break
    if (!done && locked) begin
      span = ev.now_ms - break_start;
      if (!(span > brk_ms)) begin
        r.verdict = tbkg_pkg::VERDICT_ABORT;
        done = 1'b1;
      end else begin
        locked = 1'b0;
        begin_session(ev.now_ms);
        r.lock_event = tbkg_pkg::LOCK_EVENT_ENDED;
      end
    end

    // unlocked press: idle restart, then break or count
    if (!done) begin
      span = ev.now_ms - last_press;
      if (span > idle_ms) begin_session(ev.now_ms);
      span = ev.now_ms - session_start;
      due = (left_lim != 0 && left_n >= left_lim) ||
            (right_lim != 0 && right_n >= right_lim) ||
            (sess_ms != 0 && span > sess_ms);
      if (due) begin
        locked = 1'b1;
        break_start = last_press;
        r.verdict = tbkg_pkg::VERDICT_CONSUMED;
        r.lock_event = tbkg_pkg::LOCK_EVENT_STARTED;
      end else begin
        if (ev.key_column < tbkg_pkg::HALF_COLUMNS) left_n = left_n + 16'd1;
        else right_n = right_n + 16'd1;
        last_press = ev.now_ms;
      end
    end

    r.is_locked = locked;
    r.left_presses = left_n;
    r.right_presses = right_n;
    if (locked) begin
      secs = {16'h0, break_cfg} - (ev.now_ms / 32'd1000 - break_start / 32'd1000);
      r.break_seconds_left = secs[15:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 50) $display("MISMATCH: %s", msg);
  endtask

  task automatic check_field(string name, int unsigned idx, logic [31:0] got,
                             logic [31:0] want_v);
    if (got !== want_v)
      report_mismatch($sformatf("word %0d %s got %0d expected %0d", idx, name, got, want_v));
  endtask

  // event sender: random gap, then hold the word until accepted
  initial begin : drive_events
    tbkg_pkg::in_word_t  ev;
    tbkg_pkg::out_word_t want;
    int unsigned gap;
    in_valid = 1'b0;
    in_data = '0;
    tx_busy = 1'b0;
    forever begin
      if (pending_events.size() == 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end else begin
        ev = pending_events.pop_front();
        tx_busy = 1'b1;
        gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= ev;
        do @(posedge clk); while (in_ready !== 1'b1 || rst);
        want = gate_key_event(ev);
        expected_words.push_back(want);
        events_total++;
        if (ev.is_release) releases_seen++;
        if (want.verdict == tbkg_pkg::VERDICT_ABORT) aborts_seen++;
        if (want.lock_event == tbkg_pkg::LOCK_EVENT_STARTED) breaks_started++;
        if (want.lock_event == tbkg_pkg::LOCK_EVENT_ENDED) breaks_ended++;
        tx_busy = 1'b0;
      end
    end
  end

  // result receiver ready: long hold first, then per-word stall
  initial begin : drive_ready
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin : check_words
    tbkg_pkg::out_word_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing expected", words_checked));
      end else begin
        want = expected_words.pop_front();
        check_field("verdict", words_checked, out_data.verdict, want.verdict);
        check_field("lock_event", words_checked, out_data.lock_event, want.lock_event);
        check_field("is_locked", words_checked, out_data.is_locked, want.is_locked);
        check_field("left_presses", words_checked, out_data.left_presses,
                    want.left_presses);
        check_field("right_presses", words_checked, out_data.right_presses,
                    want.right_presses);
        check_field("break_seconds_left", words_checked, out_data.break_seconds_left,
                    want.break_seconds_left);
      end
      words_checked++;
      stall_left = rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    end
  end

  // watchdog
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words still expected", cycle_count,
             expected_words.size());
    $display("Simulation FAILED");
    $finish;
  end

  // advance the scenario clock and queue one key event
  task automatic queue_event(logic rel, logic [3:0] col, logic [31:0] dt);
    tbkg_pkg::in_word_t ev;
    while (pending_events.size() >= 4) @(posedge clk);
    clock_ms = clock_ms + dt;
    ev.now_ms = clock_ms;
    ev.is_release = rel;
    ev.key_column = col;
    pending_events.push_back(ev);
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0 || tx_busy || expected_words.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tbkg_pkg::CFG_IDLE_LIMIT:    idle_cfg = val;
      tbkg_pkg::CFG_SESSION_LIMIT: session_cfg = val;
      tbkg_pkg::CFG_BREAK_LENGTH:  break_cfg = val;
      tbkg_pkg::CFG_LEFT_LIMIT:    left_lim = val;
      tbkg_pkg::CFG_RIGHT_LIMIT:   right_lim = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [15:0] idle_s, logic [15:0] sess_s,
                                logic [15:0] brk_s, logic [15:0] left_k,
                                logic [15:0] right_k);
    wait_idle();
    write_reg(tbkg_pkg::CFG_IDLE_LIMIT, idle_s);
    write_reg(tbkg_pkg::CFG_SESSION_LIMIT, sess_s);
    write_reg(tbkg_pkg::CFG_BREAK_LENGTH, brk_s);
    write_reg(tbkg_pkg::CFG_LEFT_LIMIT, left_k);
    write_reg(tbkg_pkg::CFG_RIGHT_LIMIT, right_k);
  endtask

  // reset settings: hand split, release, idle boundary
  task automatic test_default_settings();
    queue_event(1'b0, 4'd0, 32'd100);
    queue_event(1'b0, 4'd7, 32'd100);
    queue_event(1'b0, 4'd8, 32'd100);
    queue_event(1'b0, 4'd15, 32'd100);
    queue_event(1'b1, 4'd5, 32'd10);
    // gap equal to the idle limit keeps the session, one more ms restarts it
    queue_event(1'b0, 4'd2, 32'd299990);
    queue_event(1'b0, 4'd9, 32'd300001);
  endtask

  // session timeout starts a break, a press aborts, break runs out
  task automatic test_session_break();
    apply_settings(16'd5, 16'd2, 16'd3, 16'd0, 16'd0);
    queue_event(1'b0, 4'd1, 32'd1000);
    queue_event(1'b0, 4'd9, 32'd1500);
    queue_event(1'b0, 4'd4, 32'd1000);
    queue_event(1'b0, 4'd4, 32'd500);
    queue_event(1'b1, 4'd4, 32'd10);
    queue_event(1'b0, 4'd10, 32'd4000);
  endtask

  // per-hand key limits
  task automatic test_key_limits();
    apply_settings(16'd65535, 16'd0, 16'd1, 16'd2, 16'd1);
    queue_event(1'b0, 4'd0, 32'd10);
    queue_event(1'b0, 4'd1, 32'd10);
    queue_event(1'b0, 4'd2, 32'd10);
    queue_event(1'b0, 4'd12, 32'd5000);
    queue_event(1'b0, 4'd13, 32'd10);
  endtask

  // millisecond clock wraps inside a session and inside a break
  task automatic test_time_wrap();
    apply_settings(16'd1, 16'd1, 16'd2, 16'd0, 16'd0);
    clock_ms = 32'hFFFF_FA00;
    queue_event(1'b0, 4'd15, 32'd0);
    queue_event(1'b0, 4'd0, 32'd800);
    queue_event(1'b0, 4'd6, 32'd800);
    queue_event(1'b0, 4'd9, 32'd700);
    queue_event(1'b1, 4'd8, 32'd1);
  endtask

  // receiver holds off so the block fills, the test waits for all results, then a run with random gaps and stalls
  task automatic test_backpressure();
    wait_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_left = 120;
    for (int k = 0; k < 40; k++)
      queue_event(1'($urandom_range(0, 3) == 0), 4'($urandom_range(0, 15)),
                  32'($urandom_range(0, 1500)));
    wait_idle();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int k = 0; k < 20; k++)
      queue_event(1'b0, 4'($urandom_range(0, 15)), 32'($urandom_range(0, 3000)));
  endtask

  // long run on one hand with key, session and break limits off and idle limit at its maximum, then the other hand
  task automatic test_one_hand_run();
    apply_settings(16'd65535, 16'd0, 16'd0, 16'd0, 16'd0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int k = 0; k < 27; k++) queue_event(1'b0, 4'd3, 32'd1);
    for (int k = 0; k < 3; k++) queue_event(1'b0, 4'd12, 32'd1);
  endtask

  // random event streams under several settings, extremes included
  task automatic test_random_settings();
    int unsigned pick;
    int unsigned idle_span;
    int unsigned brk_span;
    logic [31:0] dt;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: apply_settings(16'd0, 16'd0, 16'd0, 16'd1, 16'd1);
        3: apply_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)));
        default: apply_settings(16'($urandom_range(0, 8)), 16'($urandom_range(0, 15)),
                                16'($urandom_range(0, 6)), 16'($urandom_range(0, 12)),
                                16'($urandom_range(0, 12)));
      endcase
      idle_span = 2 * idle_cfg * 1000 + 2000;
      brk_span = (break_cfg + session_cfg) * 1000 + 2000;
      for (int k = 0; k < 180; k++) begin
        // switch idling on and off in stretches
        if (k % 40 == 0) begin
          tx_idle_on = $urandom_range(0, 2) != 0;
          rx_idle_on = $urandom_range(0, 2) != 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) dt = $urandom_range(0, 1500);
        else if (pick < 80) dt = $urandom_range(0, idle_span);
        else if (pick < 95) dt = $urandom_range(0, brk_span);
        else dt = $urandom();
        queue_event(1'($urandom_range(0, 4) == 0), 4'($urandom_range(0, 15)), dt);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = tbkg_pkg::CFG_IDLE_LIMIT;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_settings();
    test_session_break();
    test_key_limits();
    test_time_wrap();
    test_backpressure();
    test_one_hand_run();
    test_random_settings();

    wait_idle();
    repeat (10) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
    $display("checked %0d words from %0d key events: %0d releases, %0d aborted presses",
             words_checked, events_total, releases_seen, aborts_seen);
    $display("%0d breaks started, %0d ended; defaults, limits, time wrap, one-hand run, %s",
             breaks_started, breaks_ended, "back pressure and 8 random setting phases");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
